FILE: design/stack_bytecode_executor_unit_assert.svh
// Assertion macros shared by the stack bytecode executor RTL.
`ifndef STACK_BYTECODE_EXECUTOR_UNIT_ASSERT_SVH
`define STACK_BYTECODE_EXECUTOR_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SBE_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define SBE_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sbe_pkg.sv
// Package with types and constants of the stack bytecode executor.
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;

   // Data memory size in bytes and its index width.
   localparam int MEM_BYTES = 65536;
   localparam int ADDR_W = $clog2(MEM_BYTES);

   // Opcodes.
   localparam logic [7:0] OP_NOOP = 8'h00;
   localparam logic [7:0] OP_PUSH = 8'h01;
   localparam logic [7:0] OP_POP  = 8'h02;
   localparam logic [7:0] OP_C8   = 8'h03;
   localparam logic [7:0] OP_C16  = 8'h04;
   localparam logic [7:0] OP_C32  = 8'h05;
   localparam logic [7:0] OP_DUP  = 8'h06;
   localparam logic [7:0] OP_SWAP = 8'h07;
   localparam logic [7:0] OP_ADD  = 8'h10;
   localparam logic [7:0] OP_SUB  = 8'h11;
   localparam logic [7:0] OP_MUL  = 8'h12;
   localparam logic [7:0] OP_DIV  = 8'h13;
   localparam logic [7:0] OP_MOD  = 8'h14;
   localparam logic [7:0] OP_NEG  = 8'h15;
   localparam logic [7:0] OP_ABS  = 8'h16;
   localparam logic [7:0] OP_OUT  = 8'hA0;

   // Result kinds.
   localparam logic [2:0] KIND_CHAR = 3'd0;
   localparam logic [2:0] KIND_DONE = 3'd1;
   localparam logic [2:0] KIND_OVF  = 3'd2;
   localparam logic [2:0] KIND_ILL  = 3'd3;
   localparam logic [2:0] KIND_DIV0 = 3'd4;
   localparam logic [2:0] KIND_NONE = 3'd0;

   // Configuration register indexes and reset values.
   localparam logic [1:0] CSR_FLOOR = 2'd0;
   localparam logic [1:0] CSR_START = 2'd1;
   localparam logic [15:0] FLOOR_RESET = 16'd1000;
   localparam logic [15:0] START_RESET = 16'd65535;

   // Iterations of the divider.
   localparam logic [5:0] DIV_STEPS = 6'd32;

   // Classified instruction passed from the front to the back.
   typedef struct packed {
      logic [7:0]  opcode;
      logic [15:0] var_address;
      logic [31:0] value;
      logic        last;
      logic        illegal;
      logic        is_push;
      logic [1:0]  n_reads;
      logic [1:0]  n_writes;
   } sbe_instr_type;

endpackage
`default_nettype wire

FILE: design/sbe_front.sv
// Front end: accepts instructions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sbe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_opcode,
   input  logic [15:0]           req_var_address,
   input  logic signed [31:0]    req_immediate,
   input  logic                  req_last_instruction,
   input  logic                  hold,
   output sbe_pkg::sbe_instr_type ins,
   output logic                  ins_valid,
   input  logic                  ins_take
);
   import sbe_pkg::*;

   sbe_instr_type q_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   sbe_instr_type cls;
   logic          accept;
   logic          take;

   // Classify the incoming opcode.
   always_comb begin
      cls.opcode      = req_opcode;
      cls.var_address = req_var_address;
      cls.value       = req_immediate;
      cls.last        = req_last_instruction;
      cls.illegal     = 1'b0;
      cls.is_push     = 1'b0;
      cls.n_reads     = 2'd0;
      cls.n_writes    = 2'd0;
      unique case (req_opcode)
         OP_NOOP: begin
         end
         OP_PUSH, OP_DUP: begin
            cls.is_push = 1'b1; cls.n_reads = 2'd1; cls.n_writes = 2'd1;
         end
         OP_POP, OP_NEG, OP_ABS: begin
            cls.n_reads = 2'd1; cls.n_writes = 2'd1;
         end
         OP_C8: begin
            cls.is_push = 1'b1; cls.n_writes = 2'd1;
            cls.value = {{24{req_immediate[7]}}, req_immediate[7:0]};
         end
         OP_C16: begin
            cls.is_push = 1'b1; cls.n_writes = 2'd1;
            cls.value = {{16{req_immediate[15]}}, req_immediate[15:0]};
         end
         OP_C32: begin
            cls.is_push = 1'b1; cls.n_writes = 2'd1;
         end
         OP_SWAP: begin
            cls.n_reads = 2'd2; cls.n_writes = 2'd2;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            cls.n_reads = 2'd2; cls.n_writes = 2'd1;
         end
         OP_OUT: begin
            cls.n_reads = 2'd1;
         end
         default: begin
            cls.illegal = 1'b1;
         end
      endcase
   end

   // Two-entry queue toward the back end.
   assign req_full  = (cnt_ff == 2'd2) || hold;
   assign accept    = req_push && !req_full;
   assign ins_valid = (cnt_ff != 2'd0);
   assign ins       = q_ff[rd_ptr_ff];
   assign take      = ins_take && ins_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ take;
      cnt_in    = cnt_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (accept) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

FILE: design/sbe_divider.sv
// Iterative signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sbe_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   import sbe_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  step_ff, step_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] ub_ff, ub_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // Restoring step on magnitudes.
   always_comb begin
      shifted  = {rem_ff, quo_ff[31]};
      diff     = shifted - {1'b0, ub_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      ub_in    = ub_ff;
      negq_in  = negq_ff;
      negr_in  = negr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEPS;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         ub_in   = divisor[31] ? (32'd0 - divisor) : divisor;
         rem_in  = 32'd0;
         negq_in = dividend[31] ^ divisor[31];
         negr_in = dividend[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff - 6'd1;
         if (step_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      ub_ff   <= ub_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   // Sign correction of the results.
   assign done      = done_ff;
   assign quotient  = negq_ff ? (32'd0 - quo_ff) : quo_ff;
   assign remainder = negr_ff ? (32'd0 - rem_ff) : rem_ff;

endmodule
`default_nettype wire

FILE: design/sbe_back.sv
// Back end: byte memory, stack pointer, instruction sequencer and result queue.
`timescale 1ns / 1ps
`default_nettype none
module sbe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sbe_pkg::sbe_instr_type ins,
   input  logic                   ins_valid,
   output logic                   ins_take,
   output logic                   clearing,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [2:0]             rsp_kind,
   output logic [7:0]             rsp_out_char
);
   import sbe_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_RWAIT = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WR    = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam logic [ADDR_W-1:0] MEM_LAST = ADDR_W'(MEM_BYTES - 1);

   logic [7:0]        mem [MEM_BYTES];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic [7:0]        rdata_ff;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        cnt_ff, cnt_in;
   sbe_instr_type     cur_ff, cur_in;
   logic [31:0]       w0_ff, w0_in, w1_ff, w1_in;
   logic [31:0]       res_ff, res_in;
   logic [2:0]        fault_ff, fault_in;
   logic [15:0]       sp_ff, sp_in;
   logic [15:0]       floor_ff, floor_in;
   logic              halted_ff, halted_in;
   logic              pend_ff, pend_in;
   logic [2:0]        pend_idx_ff, pend_idx_in;
   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic [2:0]        kind_q_ff [4];
   logic [7:0]        char_q_ff [4];
   logic [1:0]        qwr_ff, qwr_in, qrd_ff, qrd_in;
   logic [2:0]        qcnt_ff, qcnt_in;
   logic [1:0]        n_enq;
   logic [2:0]        e0_kind, e1_kind;
   logic [7:0]        e0_char;
   logic              deq;

   logic [15:0]       nos, spm4;
   logic [17:0]       nsp;
   logic              ovf;
   logic [15:0]       ra, rb, wa0, wa1, byte_addr;
   logic [31:0]       wd0, wd1, wword;
   logic              last_byte;
   logic              is_arith;
   logic              div_start, div_done;
   logic [31:0]       div_q, div_r;

   sbe_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (w0_ff),
      .divisor   (w1_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Data memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Stack addresses and the floor check.
   assign nos  = sp_ff + 16'd4;
   assign spm4 = sp_ff - 16'd4;
   assign nsp  = {2'b00, sp_ff} - 18'd4;
   assign ovf  = nsp[17] || (nsp[16:0] < {1'b0, floor_ff});

   assign is_arith = (cur_ff.opcode == OP_ADD) || (cur_ff.opcode == OP_SUB) ||
                     (cur_ff.opcode == OP_MUL) || (cur_ff.opcode == OP_DIV) ||
                     (cur_ff.opcode == OP_MOD);

   // Word addresses and write data per opcode.
   always_comb begin
      ra  = sp_ff;
      rb  = nos;
      wa0 = sp_ff;
      wa1 = nos;
      wd0 = res_ff;
      wd1 = w0_ff;
      if (cur_ff.opcode == OP_PUSH) begin
         ra = cur_ff.var_address;
      end else if (is_arith) begin
         ra = nos;
         rb = sp_ff;
      end
      if (cur_ff.is_push) begin
         wa0 = spm4;
      end else if (cur_ff.opcode == OP_POP) begin
         wa0 = cur_ff.var_address;
      end else if (is_arith) begin
         wa0 = nos;
      end
      if (cur_ff.opcode == OP_C8 || cur_ff.opcode == OP_C16 ||
          cur_ff.opcode == OP_C32) begin
         wd0 = cur_ff.value;
      end else if (cur_ff.opcode == OP_PUSH || cur_ff.opcode == OP_DUP ||
                   cur_ff.opcode == OP_POP) begin
         wd0 = w0_ff;
      end else if (cur_ff.opcode == OP_SWAP) begin
         wd0 = w1_ff;
      end
   end

   assign last_byte = (cnt_ff[1:0] == 2'b11) &&
                      (cnt_ff[2] == ((state_ff == ST_RD) ? (cur_ff.n_reads == 2'd2)
                                                         : (cur_ff.n_writes == 2'd2)));

   // Byte address and write byte for the current word transfer.
   always_comb begin
      byte_addr = (cnt_ff[2] ? ((state_ff == ST_RD) ? rb : wa1)
                             : ((state_ff == ST_RD) ? ra : wa0)) + {14'd0, cnt_ff[1:0]};
      wword = cnt_ff[2] ? wd1 : wd0;
      case (cnt_ff[1:0])
         2'd0:    mem_wdata = wword[7:0];
         2'd1:    mem_wdata = wword[15:8];
         2'd2:    mem_wdata = wword[23:16];
         default: mem_wdata = wword[31:24];
      endcase
      mem_raddr = byte_addr[ADDR_W-1:0];
      mem_we    = (state_ff == ST_WR);
      mem_waddr = byte_addr[ADDR_W-1:0];
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = 8'd0;
      end
   end

   // Result queue read side.
   assign rsp_empty    = (qcnt_ff == 3'd0);
   assign rsp_kind     = kind_q_ff[qrd_ff];
   assign rsp_out_char = char_q_ff[qrd_ff];
   assign deq          = rsp_pop && !rsp_empty;

   assign clearing  = clr_ff;
   assign csr_ready = 1'b1;
   assign ins_take  = (state_ff == ST_IDLE) && ins_valid && !clr_ff &&
                      (halted_ff || (qcnt_ff <= 3'd2));

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      w0_in       = w0_ff;
      w1_in       = w1_ff;
      res_in      = res_ff;
      fault_in    = fault_ff;
      sp_in       = sp_ff;
      floor_in    = floor_ff;
      halted_in   = halted_ff;
      pend_in     = 1'b0;
      pend_idx_in = cnt_ff;
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      div_start   = 1'b0;
      n_enq       = 2'd0;
      e0_kind     = KIND_NONE;
      e0_char     = 8'd0;
      e1_kind     = KIND_DONE;

      // Clearing pass after reset.
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == MEM_LAST) begin
            clr_in = 1'b0;
         end
      end

      // Read data capture, in the cycle after each issued byte.
      if (pend_ff) begin
         if (pend_idx_ff[2]) begin
            w1_in[{pend_idx_ff[1:0], 3'b000} +: 8] = rdata_ff;
         end else begin
            w0_in[{pend_idx_ff[1:0], 3'b000} +: 8] = rdata_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = 3'd0;
            if (ins_take && !halted_ff) begin
               cur_in   = ins;
               fault_in = KIND_NONE;
               if (ins.illegal) begin
                  fault_in = KIND_ILL;
                  state_in = ST_FIN;
               end else if (ins.is_push && ovf) begin
                  fault_in = KIND_OVF;
                  state_in = ST_FIN;
               end else if (ins.n_reads != 2'd0) begin
                  state_in = ST_RD;
               end else if (ins.n_writes != 2'd0) begin
                  state_in = ST_WR;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_RD: begin
            pend_in = 1'b1;
            cnt_in  = cnt_ff + 3'd1;
            if (last_byte) begin
               cnt_in   = 3'd0;
               state_in = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (cur_ff.n_writes != 2'd0) ? ST_WR : ST_FIN;
            case (cur_ff.opcode)
               OP_ADD: res_in = w0_ff + w1_ff;
               OP_SUB: res_in = w0_ff - w1_ff;
               OP_MUL: res_in = w0_ff * w1_ff;
               OP_NEG: res_in = 32'd0 - w0_ff;
               OP_ABS: res_in = w0_ff[31] ? (32'd0 - w0_ff) : w0_ff;
               OP_DIV, OP_MOD: begin
                  if (w1_ff == 32'd0) begin
                     fault_in = KIND_DIV0;
                     state_in = ST_FIN;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               default: res_in = res_ff;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = (cur_ff.opcode == OP_DIV) ? div_q : div_r;
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            cnt_in = cnt_ff + 3'd1;
            if (last_byte) begin
               cnt_in   = 3'd0;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
            if (fault_ff != KIND_NONE) begin
               n_enq     = 2'd1;
               e0_kind   = fault_ff;
               halted_in = 1'b1;
            end else begin
               if (cur_ff.is_push) begin
                  sp_in = spm4;
               end else if (cur_ff.opcode == OP_POP || cur_ff.opcode == OP_OUT ||
                            is_arith) begin
                  sp_in = nos;
               end
               if (cur_ff.opcode == OP_OUT) begin
                  e0_kind = KIND_CHAR;
                  e0_char = w0_ff[7:0];
                  n_enq   = cur_ff.last ? 2'd2 : 2'd1;
               end else if (cur_ff.last) begin
                  e0_kind = KIND_DONE;
                  n_enq   = 2'd1;
               end
               if (cur_ff.last) begin
                  halted_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes; a new start value loads the stack pointer at once.
      if (csr_valid) begin
         case (csr_index)
            CSR_FLOOR: floor_in = csr_data;
            CSR_START: sp_in    = csr_data;
            default:   floor_in = floor_ff;
         endcase
      end
   end

   // Result queue pointers.
   always_comb begin
      qwr_in  = qwr_ff + n_enq;
      qrd_in  = qrd_ff + {1'b0, deq};
      qcnt_in = qcnt_ff + {1'b0, n_enq} - {2'b00, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= 3'd0;
         fault_ff    <= KIND_NONE;
         sp_ff       <= START_RESET;
         floor_ff    <= FLOOR_RESET;
         halted_ff   <= 1'b0;
         pend_ff     <= 1'b0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         qwr_ff      <= 2'd0;
         qrd_ff      <= 2'd0;
         qcnt_ff     <= 3'd0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         fault_ff    <= fault_in;
         sp_ff       <= sp_in;
         floor_ff    <= floor_in;
         halted_ff   <= halted_in;
         pend_ff     <= pend_in;
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         qwr_ff      <= qwr_in;
         qrd_ff      <= qrd_in;
         qcnt_ff     <= qcnt_in;
      end
      cur_ff      <= cur_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      res_ff      <= res_in;
      pend_idx_ff <= pend_idx_in;
      if (n_enq != 2'd0) begin
         kind_q_ff[qwr_ff] <= e0_kind;
         char_q_ff[qwr_ff] <= e0_char;
      end
      if (n_enq == 2'd2) begin
         kind_q_ff[qwr_ff + 2'd1] <= e1_kind;
         char_q_ff[qwr_ff + 2'd1] <= 8'd0;
      end
   end

endmodule
`default_nettype wire

FILE: design/stack_bytecode_executor_unit.sv
// Top level of the stack bytecode executor.
//
//   Channel  Direction  Handshake            Payload
//   req      in         push / full          opcode, var_address, immediate, last_instruction
//   rsp      out        empty / pop          kind, out_char
//   csr      in         valid / ready        index, data
//
// An instruction reads and writes its words byte by byte through the data memory:
// the back end steps from idle through read, read wait, execute, divide (for divide
// and modulo only), write and finish, skipping the read states when it reads none.
// After reset a clearing pass zeroes every byte of the memory while full stays high.
// The front queue holds two instructions; the result queue holds four results and
// an instruction starts only with room for two.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_bytecode_executor_unit_assert.svh"
module stack_bytecode_executor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_opcode,
   input  logic [15:0]        req_var_address,
   input  logic signed [31:0] req_immediate,
   input  logic               req_last_instruction,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_out_char,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import sbe_pkg::*;

   sbe_instr_type ins;
   logic          ins_valid;
   logic          ins_take;
   logic          clearing;

   // Front end and instruction queue.
   sbe_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_opcode           (req_opcode),
      .req_var_address      (req_var_address),
      .req_immediate        (req_immediate),
      .req_last_instruction (req_last_instruction),
      .hold                 (clearing),
      .ins                  (ins),
      .ins_valid            (ins_valid),
      .ins_take             (ins_take)
   );

   // Back end with memory and result queue.
   sbe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .ins          (ins),
      .ins_valid    (ins_valid),
      .ins_take     (ins_take),
      .clearing     (clearing),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_kind     (rsp_kind),
      .rsp_out_char (rsp_out_char)
   );

   // Checks.
   `SBE_ASSERT_NEXT(a_clear_holds_input, clock, 1'b0, reset, req_full, "input open after reset")
   `SBE_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty, "result after reset")
   `SBE_ASSERT_SAME(a_char_only, clock, reset, !rsp_empty && rsp_kind != KIND_CHAR, rsp_out_char == 8'd0, "nonzero char on status")
   `SBE_ASSERT_SAME(a_kind_range, clock, reset, !rsp_empty, rsp_kind <= KIND_DIV0, "bad result kind")

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the stack bytecode executor unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import sbe_pkg::*;

   // One instruction with the results it is predicted to cause.
   typedef struct {
      logic [7:0]        opcode;
      logic [15:0]       var_address;
      logic [31:0]       immediate;
      logic              last;
      int                n_results;
      logic [1:0][2:0]   kinds;
      logic [1:0][7:0]   chars;
   } instr_type;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] out_char;
   } result_type;

   localparam int IDLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_opcode = '0;
   logic [15:0]        req_var_address = '0;
   logic signed [31:0] req_immediate = '0;
   logic               req_last_instruction = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [2:0]         rsp_kind;
   logic [7:0]         rsp_out_char;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   // Machine state mirrored by the predictor.
   logic [7:0]  shadow_mem [0:MEM_BYTES-1];
   logic [15:0] shadow_sp;
   logic [15:0] shadow_floor;
   logic [15:0] shadow_start;
   bit          shadow_halted;

   instr_type  pending_instrs[$];
   result_type expected_results[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      req_taken = 1'b0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      stall_mode = 0;
   int      stall_count = 0;

   logic [7:0] legal_ops [16] = '{OP_NOOP, OP_PUSH, OP_POP, OP_C8, OP_C16, OP_C32, OP_DUP,
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NEG, OP_ABS, OP_OUT};

   stack_bytecode_executor_unit uut (.*);

   always #5 clock = ~clock;

   // Little-endian word access with 16-bit address wrap.
   function automatic logic [31:0] mem_read(logic [15:0] addr);
      logic [31:0] v;
      logic [15:0] a;
      for (int i = 0; i < 4; i++) begin
         a = addr + 16'(i);
         v[8*i +: 8] = shadow_mem[a % MEM_BYTES];
      end
      return v;
   endfunction

   task automatic mem_write(logic [15:0] addr, logic [31:0] v);
      logic [15:0] a;
      for (int i = 0; i < 4; i++) begin
         a = addr + 16'(i);
         shadow_mem[a % MEM_BYTES] = v[8*i +: 8];
      end
   endtask

   function automatic bit push_blocked();
      return (int'(shadow_sp) - 4) < int'(shadow_floor);
   endfunction

   // True when the instruction would fault in the current state.
   function automatic bit would_fault(logic [7:0] op);
      case (op)
         OP_PUSH, OP_C8, OP_C16, OP_C32, OP_DUP: return push_blocked();
         OP_DIV, OP_MOD: return mem_read(shadow_sp) == 32'd0;
         OP_NOOP, OP_POP, OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_ABS, OP_OUT: return 1'b0;
         default: return 1'b1;
      endcase
   endfunction

   // Execute one instruction on the shadow state and record its results.
   task automatic execute_instr(inout instr_type it);
      logic [15:0] nos;
      logic [31:0] a, b, r, pushed;
      logic [2:0]  fault;
      bit          do_push;
      nos = shadow_sp + 16'd4;
      fault = KIND_CHAR;
      do_push = 1'b0;
      pushed = '0;
      it.n_results = 0;
      it.kinds = '0;
      it.chars = '0;
      if (shadow_halted) return;
      case (it.opcode)
         OP_NOOP: ;
         OP_PUSH: begin pushed = mem_read(it.var_address); do_push = 1'b1; end
         OP_POP: begin
            mem_write(it.var_address, mem_read(shadow_sp));
            shadow_sp = nos;
         end
         OP_C8: begin pushed = {{24{it.immediate[7]}}, it.immediate[7:0]}; do_push = 1'b1; end
         OP_C16: begin pushed = {{16{it.immediate[15]}}, it.immediate[15:0]}; do_push = 1'b1; end
         OP_C32: begin pushed = it.immediate; do_push = 1'b1; end
         OP_DUP: begin pushed = mem_read(shadow_sp); do_push = 1'b1; end
         OP_SWAP: begin
            a = mem_read(shadow_sp);
            b = mem_read(nos);
            mem_write(shadow_sp, b);
            mem_write(nos, a);
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            a = mem_read(nos);
            b = mem_read(shadow_sp);
            if (it.opcode == OP_ADD) r = a + b;
            else if (it.opcode == OP_SUB) r = a - b;
            else if (it.opcode == OP_MUL) r = a * b;
            else if (b == 32'd0) fault = KIND_DIV0;
            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
               r = (it.opcode == OP_DIV) ? 32'h8000_0000 : 32'd0;
            else if (it.opcode == OP_DIV) r = $signed(a) / $signed(b);
            else r = $signed(a) % $signed(b);
            if (fault == KIND_CHAR) begin
               mem_write(nos, r);
               shadow_sp = nos;
            end
         end
         OP_NEG: mem_write(shadow_sp, 32'd0 - mem_read(shadow_sp));
         OP_ABS: begin
            a = mem_read(shadow_sp);
            mem_write(shadow_sp, a[31] ? 32'd0 - a : a);
         end
         OP_OUT: begin
            a = mem_read(shadow_sp);
            shadow_sp = nos;
            it.kinds[0] = KIND_CHAR;
            it.chars[0] = a[7:0];
            it.n_results = 1;
         end
         default: fault = KIND_ILL;
      endcase
      // Every push checks the floor and leaves the state alone on overflow.
      if (do_push) begin
         if (push_blocked()) fault = KIND_OVF;
         else begin
            shadow_sp = shadow_sp - 16'd4;
            mem_write(shadow_sp, pushed);
         end
      end
      if (fault != KIND_CHAR) begin
         it.kinds[it.n_results] = fault;
         it.chars[it.n_results] = 8'd0;
         it.n_results++;
         shadow_halted = 1'b1;
      end else if (it.last) begin
         it.kinds[it.n_results] = KIND_DONE;
         it.chars[it.n_results] = 8'd0;
         it.n_results++;
         shadow_halted = 1'b1;
      end
   endtask

   // Queue an instruction; a non-terminal one that would fault becomes a pop.
   task automatic issue_instr(logic [7:0] op, logic [15:0] addr, logic [31:0] imm,
                              logic last, bit terminal);
      instr_type it;
      if (!terminal && !shadow_halted && would_fault(op)) op = OP_POP;
      it.opcode = op;
      it.var_address = addr;
      it.immediate = imm;
      it.last = terminal ? last : 1'b0;
      execute_instr(it);
      pending_instrs.push_back(it);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'd0;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] random_address();
      if ($urandom_range(0, 1)) return 16'(($urandom_range(0, 7) * 4) + $urandom_range(0, 3));
      return 16'($urandom);
   endfunction

   // Mostly well-formed traffic: constants pushed, then worked on and printed.
   task automatic issue_random(int count);
      logic [7:0] op;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: op = legal_ops[$urandom_range(3, 5)];
            3: op = $urandom_range(0, 1) ? OP_PUSH : OP_POP;
            4: op = OP_OUT;
            default: op = legal_ops[$urandom_range(0, 15)];
         endcase
         issue_instr(op, random_address(), random_value(), 1'b0, 1'b0);
      end
   endtask

   // Wait until all queued instructions are taken and their results returned.
   task automatic drain();
      while (pending_instrs.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FLOOR) shadow_floor = val;
      else begin
         shadow_start = val;
         shadow_sp = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      bit drive;
      drive = 1'b0;
      if (!req_push || req_taken) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (pending_instrs.size() != 0) begin
            drive = 1'b1;
            req_opcode <= pending_instrs[0].opcode;
            req_var_address <= pending_instrs[0].var_address;
            req_immediate <= pending_instrs[0].immediate;
            req_last_instruction <= pending_instrs[0].last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else burst_left <= burst_left - 1;
         end
         req_push <= drive;
      end
      req_taken <= 1'b0;
   end

   // Request acceptance: the transaction's predicted results become expected.
   always @(posedge clock) begin
      if (req_push && !req_full && pending_instrs.size() != 0) begin
         for (int i = 0; i < pending_instrs[0].n_results; i++)
            expected_results.push_back(result_type'{pending_instrs[0].kinds[i],
                                                    pending_instrs[0].chars[i]});
         void'(pending_instrs.pop_front());
         req_taken <= 1'b1;
      end
   end

   // Result receiver: alternates between free-running and stalling stretches.
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_count <= $urandom_range(16, 96);
      end else stall_count <= stall_count - 1;
      case (stall_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 3) != 0);
         default: rsp_pop <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Result monitor: each transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_results.size() == 0) begin
            $display("UNEXPECTED result kind %0d char %0h at %0t", rsp_kind, rsp_out_char,
                     $realtime);
            error_count++;
         end else begin
            if (rsp_kind !== expected_results[0].kind)
               report_mismatch("kind", rsp_kind, expected_results[0].kind);
            if (rsp_out_char !== expected_results[0].out_char)
               report_mismatch("out_char", rsp_out_char, expected_results[0].out_char);
            void'(expected_results.pop_front());
         end
      end
   end

   // Watchdog on cycles without any transaction; allows for the clearing pass.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   // Stimulus sequence.
   initial begin
      int sel;
      for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'd0;
      shadow_floor = FLOOR_RESET;
      shadow_start = START_RESET;
      shadow_sp = START_RESET;
      shadow_halted = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: sign extension, wrap cases of divide, negate and abs.
      issue_instr(OP_C8, 16'd0, 32'h0000_0080, 1'b0, 1'b0);
      issue_instr(OP_OUT, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_C16, 16'd0, 32'h1234_8000, 1'b0, 1'b0);
      issue_instr(OP_POP, 16'hFFFE, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_PUSH, 16'hFFFE, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_C32, 16'd0, 32'h8000_0000, 1'b0, 1'b0);
      issue_instr(OP_C32, 16'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
      issue_instr(OP_DIV, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_DUP, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_C8, 16'd0, 32'h0000_00FF, 1'b0, 1'b0);
      issue_instr(OP_MOD, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_OUT, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_NEG, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_ABS, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_C8, 16'd0, 32'h0000_0007, 1'b0, 1'b0);
      issue_instr(OP_C8, 16'd0, 32'h0000_00FE, 1'b0, 1'b0);
      issue_instr(OP_SWAP, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_DIV, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_C16, 16'd0, 32'h0000_7FFF, 1'b0, 1'b0);
      issue_instr(OP_MUL, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_C32, 16'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
      issue_instr(OP_ADD, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_SUB, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_OUT, 16'd0, 32'd0, 1'b0, 1'b0);
      issue_instr(OP_NOOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);

      // Random phases; the sender pauses between phases until all results are back.
      issue_random(40);
      drain();
      issue_random(40);
      drain();
      csr_write(CSR_FLOOR, 16'd0);
      csr_write(CSR_START, 16'd100);
      issue_random(70);
      drain();
      csr_write(CSR_FLOOR, 16'd65535);
      csr_write(CSR_START, 16'd65535);
      issue_random(50);
      drain();
      csr_write(CSR_FLOOR, 16'd60000);
      csr_write(CSR_START, 16'd65535);
      issue_random(80);
      drain();
      csr_write(CSR_FLOOR, 16'd0);
      csr_write(CSR_START, 16'd0);
      issue_random(50);
      drain();
      csr_write(CSR_FLOOR, 16'd2000);
      csr_write(CSR_START, 16'd4000);
      issue_random(80);

      // One terminating event, then instructions the halted machine ignores.
      sel = $urandom_range(0, 3);
      case (sel)
         0: begin
            issue_instr(OP_C8, 16'd0, 32'h41, 1'b0, 1'b0);
            issue_instr(OP_OUT, 16'd0, 32'd0, 1'b1, 1'b1);
         end
         1: issue_instr(8'h48, 16'd0, 32'd0, 1'b1, 1'b1);
         2: begin
            issue_instr(OP_C8, 16'd0, 32'd0, 1'b0, 1'b0);
            issue_instr(OP_DIV, 16'd0, 32'd0, 1'b1, 1'b1);
         end
         default: begin
            drain();
            csr_write(CSR_FLOOR, 16'd65535);
            issue_instr(OP_C32, 16'd0, 32'h55AA_55AA, 1'b1, 1'b1);
         end
      endcase
      for (int i = 0; i < 20; i++)
         issue_instr(8'($urandom), 16'($urandom), $urandom, 1'($urandom), 1'b1);
      drain();

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
